// ----- hw/rtl/bis_pkg.sv -----
// Shared constants, types and the two-bit restoring divide step for the bilinear scaler.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package bis_pkg;

   localparam int MAX_SRC_WIDTH  = 256;
   localparam int MAX_SRC_HEIGHT = 256;
   localparam int MAX_DST_DIM    = 4096;

   localparam int CHANNEL_BITS = 8;
   localparam int NUM_CHANNELS = 4;
   localparam int WORD_BITS    = CHANNEL_BITS * NUM_CHANNELS;
   localparam int CHAN_CNT_BITS = 3;

   localparam int COORD_BITS = 12;
   localparam int COL_BITS   = $clog2(MAX_SRC_WIDTH);
   localparam int ROW_BITS   = $clog2(MAX_SRC_HEIGHT);
   localparam int DIM_BITS   = $clog2(MAX_DST_DIM);

   // four banks split by column and row parity, so the 2x2 neighborhood hits each once
   localparam int NUM_BANKS      = 4;
   localparam int BANK_SEL_BITS  = 2;
   localparam int BANK_ADDR_BITS = COL_BITS + ROW_BITS - 2;
   localparam int BANK_DEPTH     = 2 ** BANK_ADDR_BITS;

   localparam int PROD_BITS   = COORD_BITS + COL_BITS;
   localparam int WEIGHT_BITS = 2 * DIM_BITS;
   localparam int REM_BITS    = WEIGHT_BITS + CHANNEL_BITS;
   localparam int QUOT_BITS   = 8;
   localparam int DIV_STAGES  = QUOT_BITS / 2;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 13;

   // pipeline stage numbers
   localparam int STG_IN     = 0;
   localparam int STG_MAP    = 1;
   localparam int STG_COORD  = STG_MAP + DIV_STAGES;
   localparam int STG_FETCH  = STG_COORD + 1;
   localparam int STG_MUL    = STG_FETCH + 1;
   localparam int STG_SUM    = STG_MUL + 1;
   localparam int STG_QUOT   = STG_SUM + DIV_STAGES;
   localparam int STG_OUT    = STG_QUOT + 1;
   localparam int NUM_STAGES = STG_OUT + 1;

   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_COMPUTE = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DST_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DST_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANNELS   = 3'd4;

   // clamped sizes; sw, sh, dw and dh are each held as size minus one
   typedef struct packed {
      logic [COL_BITS-1:0]      sw;
      logic [ROW_BITS-1:0]      sh;
      logic [DIM_BITS-1:0]      dw;
      logic [DIM_BITS-1:0]      dh;
      logic [CHAN_CNT_BITS-1:0] chans;
      logic [WEIGHT_BITS-1:0]   den;
   } cfg_type;

   typedef struct packed {
      logic [1:0]          q;
      logic [REM_BITS-1:0] rem;
   } div_pair_type;

   // two restoring steps, quotient bits top and top-1
   function automatic div_pair_type div_pair(input logic [REM_BITS-1:0]    rem,
                                             input logic [WEIGHT_BITS-1:0] dvs,
                                             input logic [2:0]             top);
      div_pair_type        res;
      logic [REM_BITS-1:0] r;
      logic [REM_BITS-1:0] d;
      r = rem;
      d = REM_BITS'(dvs) << top;
      res.q[1] = (r >= d);
      if (res.q[1]) begin
         r = r - d;
      end
      d = REM_BITS'(dvs) << (top - 3'd1);
      res.q[0] = (r >= d);
      if (res.q[0]) begin
         r = r - d;
      end
      res.rem = r;
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bilinear_image_scaler_core.sv -----
// Bilinear image scaler core: each accepted compute word yields one result word.
// Throughput one word per cycle while rsp_stall is low; the bank read and every divide are fully pipelined.
// Write words update the frame store when they reach the fetch stage and give no result.
// Reset (synchronous) clears valid bits and sets sizes to their defaults; the frame store keeps its contents.
// Depends on bis_pkg, bis_map, bis_fetch and bis_blend.
`default_nettype none

module bilinear_image_scaler_core (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_opcode,
   input  wire logic [11:0]                         req_column,
   input  wire logic [11:0]                         req_row,
   input  wire logic [7:0]                          req_chan0_in,
   input  wire logic [7:0]                          req_chan1_in,
   input  wire logic [7:0]                          req_chan2_in,
   input  wire logic [7:0]                          req_chan3_in,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [7:0]                               rsp_chan0_out,
   output logic [7:0]                               rsp_chan1_out,
   output logic [7:0]                               rsp_chan2_out,
   output logic [7:0]                               rsp_chan3_out,
   output logic                                     rsp_status,

   input  wire logic                                csr_write,
   input  wire logic [bis_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [bis_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   // Pipeline map:
   //   0      input register
   //   1      numerators col*sw, row*sh, range check
   //   2..5   coordinate divide, two quotient bits a stage
   //   6      bank read (or write), weight products
   //   7      pixel times weight
   //   8      sum plus half divisor
   //   9..12  final divide by dw*dh
   //   13     result register
   // Each stage loads when it is empty or the stage after it loads, so bubbles
   // collapse; a stalled result freezes only the unbroken run of full stages behind it.

   logic [8:0]                            src_width_ff;
   logic [8:0]                            src_height_ff;
   logic [12:0]                           dst_width_ff;
   logic [12:0]                           dst_height_ff;
   logic [bis_pkg::CHAN_CNT_BITS-1:0]     chan_cnt_ff;
   bis_pkg::cfg_type                      cfg_ff;

   logic [bis_pkg::NUM_STAGES-1:0]        v_ff;
   logic [bis_pkg::NUM_STAGES-1:0]        v_in;
   logic [bis_pkg::NUM_STAGES-1:0]        ld;

   logic                                  op_ff;
   logic [bis_pkg::COORD_BITS-1:0]        col_ff;
   logic [bis_pkg::COORD_BITS-1:0]        row_ff;
   logic [bis_pkg::WORD_BITS-1:0]         data_ff;

   logic                                  m_op;
   logic                                  m_oor;
   logic                                  m_wok;
   logic [bis_pkg::COL_BITS-1:0]          m_wcol;
   logic [bis_pkg::ROW_BITS-1:0]          m_wrow;
   logic [bis_pkg::WORD_BITS-1:0]         m_data;
   logic [bis_pkg::QUOT_BITS-1:0]         m_x;
   logic [bis_pkg::DIM_BITS-1:0]          m_rx;
   logic [bis_pkg::QUOT_BITS-1:0]         m_y;
   logic [bis_pkg::DIM_BITS-1:0]          m_ry;

   logic [bis_pkg::WORD_BITS-1:0]         f_pix [bis_pkg::NUM_BANKS];
   logic [bis_pkg::WEIGHT_BITS-1:0]       f_w   [bis_pkg::NUM_BANKS];
   logic                                  f_xpar;
   logic                                  f_ypar;
   logic                                  f_oor;

   logic [bis_pkg::CHANNEL_BITS-1:0]      b_q [bis_pkg::NUM_CHANNELS];
   logic                                  b_oor;

   logic [bis_pkg::CHANNEL_BITS-1:0]      out_chan_ff [bis_pkg::NUM_CHANNELS];
   logic                                  out_status_ff;

   // clamp a source size into 1..max and return size minus one
   function automatic logic [bis_pkg::COL_BITS-1:0] src_less_one(input logic [8:0] v);
      logic [8:0] r;
      if (v == '0) begin
         r = '0;
      end else if (v > 9'(bis_pkg::MAX_SRC_WIDTH)) begin
         r = 9'(bis_pkg::MAX_SRC_WIDTH - 1);
      end else begin
         r = v - 9'd1;
      end
      return r[bis_pkg::COL_BITS-1:0];
   endfunction

   // clamp a destination size into 2..max and return size minus one
   function automatic logic [bis_pkg::DIM_BITS-1:0] dst_less_one(input logic [12:0] v);
      logic [12:0] r;
      if (v < 13'd2) begin
         r = 13'd1;
      end else if (v > 13'(bis_pkg::MAX_DST_DIM)) begin
         r = 13'(bis_pkg::MAX_DST_DIM - 1);
      end else begin
         r = v - 13'd1;
      end
      return r[bis_pkg::DIM_BITS-1:0];
   endfunction

   // register file: take writes, drop unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= 9'd256;
         src_height_ff <= 9'd256;
         dst_width_ff  <= 13'd256;
         dst_height_ff <= 13'd256;
         chan_cnt_ff   <= 3'd4;
      end else if (csr_write) begin
         case (csr_index)
            bis_pkg::CSR_SRC_WIDTH:  src_width_ff  <= csr_data[8:0];
            bis_pkg::CSR_SRC_HEIGHT: src_height_ff <= csr_data[8:0];
            bis_pkg::CSR_DST_WIDTH:  dst_width_ff  <= csr_data;
            bis_pkg::CSR_DST_HEIGHT: dst_height_ff <= csr_data;
            bis_pkg::CSR_CHANNELS:   chan_cnt_ff   <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // clamped sizes and the final divisor, all registered
   always_ff @(posedge clock) begin
      cfg_ff.sw  <= src_less_one(src_width_ff);
      cfg_ff.sh  <= src_less_one(src_height_ff);
      cfg_ff.dw  <= dst_less_one(dst_width_ff);
      cfg_ff.dh  <= dst_less_one(dst_height_ff);
      if (chan_cnt_ff == '0) begin
         cfg_ff.chans <= 3'd1;
      end else if (chan_cnt_ff > 3'(bis_pkg::NUM_CHANNELS)) begin
         cfg_ff.chans <= 3'(bis_pkg::NUM_CHANNELS);
      end else begin
         cfg_ff.chans <= chan_cnt_ff;
      end
      cfg_ff.den <= bis_pkg::WEIGHT_BITS'(cfg_ff.dw) * bis_pkg::WEIGHT_BITS'(cfg_ff.dh);
   end

   // load enables: a stage advances when empty or when its successor advances
   always_comb begin
      ld[bis_pkg::NUM_STAGES-1] = !v_ff[bis_pkg::NUM_STAGES-1] || !rsp_stall;
      for (int k = bis_pkg::NUM_STAGES - 2; k >= 0; k--) begin
         ld[k] = !v_ff[k] || ld[k+1];
      end
   end

   // valid bits follow the data; write words leave the pipe at the fetch stage
   always_comb begin
      v_in[0] = req_valid;
      for (int k = 1; k < bis_pkg::NUM_STAGES; k++) begin
         v_in[k] = v_ff[k-1];
      end
      v_in[bis_pkg::STG_FETCH] = v_ff[bis_pkg::STG_COORD] && (m_op == bis_pkg::OP_COMPUTE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < bis_pkg::NUM_STAGES; k++) begin
            if (ld[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   assign req_stall = !ld[bis_pkg::STG_IN];

   // input register
   always_ff @(posedge clock) begin
      if (ld[bis_pkg::STG_IN]) begin
         op_ff   <= req_opcode;
         col_ff  <= req_column;
         row_ff  <= req_row;
         data_ff <= {req_chan3_in, req_chan2_in, req_chan1_in, req_chan0_in};
      end
   end

   bis_map u_map (
      .clock    (clock),
      .ld       (ld),
      .cfg      (cfg_ff),
      .op       (op_ff),
      .col      (col_ff),
      .row      (row_ff),
      .data     (data_ff),
      .op_out   (m_op),
      .oor_out  (m_oor),
      .wok_out  (m_wok),
      .wcol_out (m_wcol),
      .wrow_out (m_wrow),
      .data_out (m_data),
      .x_out    (m_x),
      .rx_out   (m_rx),
      .y_out    (m_y),
      .ry_out   (m_ry)
   );

   bis_fetch u_fetch (
      .clock    (clock),
      .ld       (ld),
      .cfg      (cfg_ff),
      .valid    (v_ff[bis_pkg::STG_COORD]),
      .op       (m_op),
      .oor      (m_oor),
      .wok      (m_wok),
      .wcol     (m_wcol),
      .wrow     (m_wrow),
      .data     (m_data),
      .x        (m_x),
      .rx       (m_rx),
      .y        (m_y),
      .ry       (m_ry),
      .pix_out  (f_pix),
      .w_out    (f_w),
      .xpar_out (f_xpar),
      .ypar_out (f_ypar),
      .oor_out  (f_oor)
   );

   bis_blend u_blend (
      .clock   (clock),
      .ld      (ld),
      .cfg     (cfg_ff),
      .pix     (f_pix),
      .w       (f_w),
      .xpar    (f_xpar),
      .ypar    (f_ypar),
      .oor     (f_oor),
      .q_out   (b_q),
      .oor_out (b_oor)
   );

   // result register: zero unused channels, zero all on a range error
   always_ff @(posedge clock) begin
      if (ld[bis_pkg::STG_OUT]) begin
         out_status_ff <= b_oor;
         for (int c = 0; c < bis_pkg::NUM_CHANNELS; c++) begin
            if (!b_oor && (3'(c) < cfg_ff.chans)) begin
               out_chan_ff[c] <= b_q[c];
            end else begin
               out_chan_ff[c] <= '0;
            end
         end
      end
   end

   assign rsp_valid     = v_ff[bis_pkg::STG_OUT];
   assign rsp_status    = out_status_ff;
   assign rsp_chan0_out = out_chan_ff[0];
   assign rsp_chan1_out = out_chan_ff[1];
   assign rsp_chan2_out = out_chan_ff[2];
   assign rsp_chan3_out = out_chan_ff[3];

endmodule

`default_nettype wire

// ----- hw/rtl/bis_map.sv -----
// Coordinate mapping: destination to source position and remainder, pipelined divide.
// Depends on bis_pkg for widths, stage numbers and the divide step.
`default_nettype none

module bis_map (
   input  wire logic                             clock,
   input  wire logic [bis_pkg::NUM_STAGES-1:0]   ld,
   input  wire bis_pkg::cfg_type                 cfg,
   input  wire logic                             op,
   input  wire logic [bis_pkg::COORD_BITS-1:0]   col,
   input  wire logic [bis_pkg::COORD_BITS-1:0]   row,
   input  wire logic [bis_pkg::WORD_BITS-1:0]    data,
   output logic                                  op_out,
   output logic                                  oor_out,
   output logic                                  wok_out,
   output logic [bis_pkg::COL_BITS-1:0]          wcol_out,
   output logic [bis_pkg::ROW_BITS-1:0]          wrow_out,
   output logic [bis_pkg::WORD_BITS-1:0]         data_out,
   output logic [bis_pkg::QUOT_BITS-1:0]         x_out,
   output logic [bis_pkg::DIM_BITS-1:0]          rx_out,
   output logic [bis_pkg::QUOT_BITS-1:0]         y_out,
   output logic [bis_pkg::DIM_BITS-1:0]          ry_out
);

   localparam int N = bis_pkg::DIV_STAGES + 1;

   logic                               op_ff   [N];
   logic                               oor_ff  [N];
   logic                               wok_ff  [N];
   logic [bis_pkg::COL_BITS-1:0]       wcol_ff [N];
   logic [bis_pkg::ROW_BITS-1:0]       wrow_ff [N];
   logic [bis_pkg::WORD_BITS-1:0]      data_ff [N];
   logic [bis_pkg::REM_BITS-1:0]       remx_ff [N];
   logic [bis_pkg::QUOT_BITS-1:0]      qx_ff   [N];
   logic [bis_pkg::REM_BITS-1:0]       remy_ff [N];
   logic [bis_pkg::QUOT_BITS-1:0]      qy_ff   [N];

   // form the numerators col*sw and row*sh, flag range errors
   always_ff @(posedge clock) begin
      if (ld[bis_pkg::STG_MAP]) begin
         op_ff[0]   <= op;
         oor_ff[0]  <= (col > cfg.dw) || (row > cfg.dh);
         wok_ff[0]  <= (col[bis_pkg::COORD_BITS-1:bis_pkg::COL_BITS] == '0) &&
                       (row[bis_pkg::COORD_BITS-1:bis_pkg::ROW_BITS] == '0);
         wcol_ff[0] <= col[bis_pkg::COL_BITS-1:0];
         wrow_ff[0] <= row[bis_pkg::ROW_BITS-1:0];
         data_ff[0] <= data;
         remx_ff[0] <= bis_pkg::REM_BITS'(bis_pkg::PROD_BITS'(col) *
                                          bis_pkg::PROD_BITS'(cfg.sw));
         remy_ff[0] <= bis_pkg::REM_BITS'(bis_pkg::PROD_BITS'(row) *
                                          bis_pkg::PROD_BITS'(cfg.sh));
         qx_ff[0]   <= '0;
         qy_ff[0]   <= '0;
      end
   end

   for (genvar j = 1; j < N; j++) begin : g_div
      bis_pkg::div_pair_type dx;
      bis_pkg::div_pair_type dy;

      assign dx = bis_pkg::div_pair(remx_ff[j-1], bis_pkg::WEIGHT_BITS'(cfg.dw),
                                    3'(bis_pkg::QUOT_BITS + 1 - 2 * j));
      assign dy = bis_pkg::div_pair(remy_ff[j-1], bis_pkg::WEIGHT_BITS'(cfg.dh),
                                    3'(bis_pkg::QUOT_BITS + 1 - 2 * j));

      always_ff @(posedge clock) begin
         if (ld[bis_pkg::STG_MAP + j]) begin
            op_ff[j]   <= op_ff[j-1];
            oor_ff[j]  <= oor_ff[j-1];
            wok_ff[j]  <= wok_ff[j-1];
            wcol_ff[j] <= wcol_ff[j-1];
            wrow_ff[j] <= wrow_ff[j-1];
            data_ff[j] <= data_ff[j-1];
            remx_ff[j] <= dx.rem;
            remy_ff[j] <= dy.rem;
            qx_ff[j]   <= {qx_ff[j-1][bis_pkg::QUOT_BITS-3:0], dx.q};
            qy_ff[j]   <= {qy_ff[j-1][bis_pkg::QUOT_BITS-3:0], dy.q};
         end
      end
   end

   assign op_out   = op_ff[N-1];
   assign oor_out  = oor_ff[N-1];
   assign wok_out  = wok_ff[N-1];
   assign wcol_out = wcol_ff[N-1];
   assign wrow_out = wrow_ff[N-1];
   assign data_out = data_ff[N-1];
   assign x_out    = qx_ff[N-1];
   assign y_out    = qy_ff[N-1];
   assign rx_out   = remx_ff[N-1][bis_pkg::DIM_BITS-1:0];
   assign ry_out   = remy_ff[N-1][bis_pkg::DIM_BITS-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/bis_fetch.sv -----
// Frame store in four parity banks plus the bilinear weight products.
// Depends on bis_pkg for widths, stage numbers and op codes.
`default_nettype none

module bis_fetch (
   input  wire logic                             clock,
   input  wire logic [bis_pkg::NUM_STAGES-1:0]   ld,
   input  wire bis_pkg::cfg_type                 cfg,
   input  wire logic                             valid,
   input  wire logic                             op,
   input  wire logic                             oor,
   input  wire logic                             wok,
   input  wire logic [bis_pkg::COL_BITS-1:0]     wcol,
   input  wire logic [bis_pkg::ROW_BITS-1:0]     wrow,
   input  wire logic [bis_pkg::WORD_BITS-1:0]    data,
   input  wire logic [bis_pkg::QUOT_BITS-1:0]    x,
   input  wire logic [bis_pkg::DIM_BITS-1:0]     rx,
   input  wire logic [bis_pkg::QUOT_BITS-1:0]    y,
   input  wire logic [bis_pkg::DIM_BITS-1:0]     ry,
   output logic [bis_pkg::WORD_BITS-1:0]         pix_out [bis_pkg::NUM_BANKS],
   output logic [bis_pkg::WEIGHT_BITS-1:0]       w_out   [bis_pkg::NUM_BANKS],
   output logic                                  xpar_out,
   output logic                                  ypar_out,
   output logic                                  oor_out
);

   logic [bis_pkg::WORD_BITS-1:0]      pix_ff [bis_pkg::NUM_BANKS];
   logic [bis_pkg::WEIGHT_BITS-1:0]    w_ff   [bis_pkg::NUM_BANKS];
   logic                               xpar_ff;
   logic                               ypar_ff;
   logic                               oor_ff;

   logic [bis_pkg::COL_BITS-1:0]       cx [2];
   logic [bis_pkg::ROW_BITS-1:0]       cy [2];
   logic                               wr_en;
   logic [bis_pkg::BANK_SEL_BITS-1:0]  wr_bank;
   logic [bis_pkg::BANK_ADDR_BITS-1:0] wr_addr;
   logic [bis_pkg::DIM_BITS-1:0]       wx0;
   logic [bis_pkg::DIM_BITS-1:0]       wy0;

   // column x and x+1 always differ in parity; the unused one carries zero weight
   always_comb begin
      cx[0] = x[0] ? (x + 1'b1) : x;
      cx[1] = x[0] ? x : (x + 1'b1);
      cy[0] = y[0] ? (y + 1'b1) : y;
      cy[1] = y[0] ? y : (y + 1'b1);
   end

   assign wr_en   = ld[bis_pkg::STG_FETCH] && valid && (op == bis_pkg::OP_WRITE) && wok;
   assign wr_bank = {wrow[0], wcol[0]};
   assign wr_addr = {wrow[bis_pkg::ROW_BITS-1:1], wcol[bis_pkg::COL_BITS-1:1]};

   for (genvar b = 0; b < bis_pkg::NUM_BANKS; b++) begin : g_bank
      localparam int PY = b / 2;
      localparam int PX = b % 2;
      logic [bis_pkg::WORD_BITS-1:0]      mem [bis_pkg::BANK_DEPTH];
      logic [bis_pkg::BANK_ADDR_BITS-1:0] rd_addr;

      assign rd_addr = {cy[PY][bis_pkg::ROW_BITS-1:1], cx[PX][bis_pkg::COL_BITS-1:1]};

      always_ff @(posedge clock) begin
         if (ld[bis_pkg::STG_FETCH]) begin
            if (wr_en && (wr_bank == bis_pkg::BANK_SEL_BITS'(b))) begin
               mem[wr_addr] <= data;
            end
            pix_ff[b] <= mem[rd_addr];
         end
      end
   end

   assign wx0 = cfg.dw - rx;
   assign wy0 = cfg.dh - ry;

   always_ff @(posedge clock) begin
      if (ld[bis_pkg::STG_FETCH]) begin
         w_ff[0] <= bis_pkg::WEIGHT_BITS'(wx0) * bis_pkg::WEIGHT_BITS'(wy0);
         w_ff[1] <= bis_pkg::WEIGHT_BITS'(rx)  * bis_pkg::WEIGHT_BITS'(wy0);
         w_ff[2] <= bis_pkg::WEIGHT_BITS'(wx0) * bis_pkg::WEIGHT_BITS'(ry);
         w_ff[3] <= bis_pkg::WEIGHT_BITS'(rx)  * bis_pkg::WEIGHT_BITS'(ry);
         xpar_ff <= x[0];
         ypar_ff <= y[0];
         oor_ff  <= oor;
      end
   end

   assign pix_out  = pix_ff;
   assign w_out    = w_ff;
   assign xpar_out = xpar_ff;
   assign ypar_out = ypar_ff;
   assign oor_out  = oor_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/bis_blend.sv -----
// Blend: pixel times weight, sum with half divisor, pipelined divide by dw*dh.
// Depends on bis_pkg for widths, stage numbers and the divide step.
`default_nettype none

module bis_blend (
   input  wire logic                             clock,
   input  wire logic [bis_pkg::NUM_STAGES-1:0]   ld,
   input  wire bis_pkg::cfg_type                 cfg,
   input  wire logic [bis_pkg::WORD_BITS-1:0]    pix [bis_pkg::NUM_BANKS],
   input  wire logic [bis_pkg::WEIGHT_BITS-1:0]  w   [bis_pkg::NUM_BANKS],
   input  wire logic                             xpar,
   input  wire logic                             ypar,
   input  wire logic                             oor,
   output logic [bis_pkg::CHANNEL_BITS-1:0]      q_out [bis_pkg::NUM_CHANNELS],
   output logic                                  oor_out
);

   localparam int N  = bis_pkg::DIV_STAGES + 1;
   localparam int NO = N + 1;

   logic [bis_pkg::REM_BITS-1:0]  prod_ff [bis_pkg::NUM_CHANNELS][bis_pkg::NUM_BANKS];
   logic [bis_pkg::REM_BITS-1:0]  rem_ff  [bis_pkg::NUM_CHANNELS][N];
   logic [bis_pkg::QUOT_BITS-1:0] q_ff    [bis_pkg::NUM_CHANNELS][N];
   logic                          oor_ff  [NO];
   logic [bis_pkg::BANK_SEL_BITS-1:0] sel [bis_pkg::NUM_BANKS];

   // term t: bit 0 steps one column right, bit 1 one row down
   for (genvar t = 0; t < bis_pkg::NUM_BANKS; t++) begin : g_sel
      assign sel[t] = {ypar ^ ((t / 2) != 0), xpar ^ ((t % 2) != 0)};
   end

   always_ff @(posedge clock) begin
      if (ld[bis_pkg::STG_MUL]) begin
         oor_ff[0] <= oor;
      end
   end

   for (genvar j = 1; j < NO; j++) begin : g_oor
      always_ff @(posedge clock) begin
         if (ld[bis_pkg::STG_MUL + j]) begin
            oor_ff[j] <= oor_ff[j-1];
         end
      end
   end

   for (genvar c = 0; c < bis_pkg::NUM_CHANNELS; c++) begin : g_chan
      for (genvar t = 0; t < bis_pkg::NUM_BANKS; t++) begin : g_term
         // a zero-weight corner may be a never-loaded entry; drop it outright
         always_ff @(posedge clock) begin
            if (ld[bis_pkg::STG_MUL]) begin
               prod_ff[c][t] <= (w[t] == '0) ? '0 :
                  bis_pkg::REM_BITS'(pix[sel[t]][c*bis_pkg::CHANNEL_BITS +:
                                                  bis_pkg::CHANNEL_BITS]) *
                  bis_pkg::REM_BITS'(w[t]);
            end
         end
      end

      // add half the divisor so the truncating divide rounds half up
      always_ff @(posedge clock) begin
         if (ld[bis_pkg::STG_SUM]) begin
            rem_ff[c][0] <= prod_ff[c][0] + prod_ff[c][1] + prod_ff[c][2] + prod_ff[c][3] +
                            bis_pkg::REM_BITS'(cfg.den >> 1);
            q_ff[c][0]   <= '0;
         end
      end

      for (genvar j = 1; j < N; j++) begin : g_div
         bis_pkg::div_pair_type dq;

         assign dq = bis_pkg::div_pair(rem_ff[c][j-1], cfg.den,
                                       3'(bis_pkg::QUOT_BITS + 1 - 2 * j));

         always_ff @(posedge clock) begin
            if (ld[bis_pkg::STG_SUM + j]) begin
               rem_ff[c][j] <= dq.rem;
               q_ff[c][j]   <= {q_ff[c][j-1][bis_pkg::QUOT_BITS-3:0], dq.q};
            end
         end
      end

      assign q_out[c] = q_ff[c][N-1];
   end

   assign oor_out = oor_ff[NO-1];

endmodule

`default_nettype wire
